### src/hmac_sha256_setup_response_unit_assert.svh
// Assertion macros for the HMAC setup response unit.
// Included by the top level; no other dependencies.
`ifndef HMAC_SHA256_SETUP_RESPONSE_UNIT_ASSERT_SVH
`define HMAC_SHA256_SETUP_RESPONSE_UNIT_ASSERT_SVH
`define HSR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hsr assertion failed");
`define HSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hsr assertion failed");
`endif

### src/hsr_pkg.sv
// Package for the HMAC setup response unit: payload types and SHA-256 constants.
// No dependencies.
package hsr_pkg;
  typedef struct packed {
    logic [47:0] device_address;
    logic [63:0] challenge_upper;
    logic [63:0] challenge_lower;
  } req_t;

  typedef struct packed {
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;
  } rsp_t;

  localparam logic [0:0] CfgKeyUpper = 1'b0;
  localparam logic [0:0] CfgKeyLower = 1'b1;

  localparam logic [255:0] HInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] kround(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction
endpackage

### src/hsr_round.sv
// One SHA-256 round and one message schedule step, shared by all four compressions.
// Depends on hsr_pkg.
module hsr_round (
  input  logic [255:0] st_i,
  input  logic [511:0] w_i,
  input  logic [5:0]   rnd_i,
  output logic [255:0] st_o,
  output logic [511:0] w_o
);
  logic [31:0] a, b, c, d, e, f, g, h, t1, t2, w0, w1, w9, w14, s0, s1;

  always_comb begin
    {a, b, c, d, e, f, g, h} = st_i;
    w0  = w_i[511:480];
    w1  = w_i[479:448];
    w9  = w_i[223:192];
    w14 = w_i[63:32];
    t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
           + ((e & f) ^ (~e & g)) + hsr_pkg::kround(rnd_i) + w0;
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
           + ((a & b) ^ (a & c) ^ (b & c));
    st_o = {t1 + t2, a, b, c, d + t1, e, f, g};
    s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b0, w1[31:3]};
    s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'b0, w14[31:10]};
    w_o = {w_i[479:0], w0 + s0 + w9 + s1};
  end
endmodule

### src/hmac_sha256_setup_response_unit.sv
// Top level of the HMAC-SHA256 setup response unit.
// Depends on hsr_pkg, hsr_round and hmac_sha256_setup_response_unit_assert.svh.
//
// channel | signals                            | handshake
// request | start_i, req_i, busy_o             | start_i && !busy_o
// result  | done_o, rsp_o                      | done_o, one cycle, no stall
// config  | cfg_valid_i, cfg_ready_o, cfg_*_i  | cfg_valid_i && cfg_ready_o
//
// An item runs four compressions, each of 64 rounds and one fold, from start to done.
// The single round unit hsr_round does one round per cycle.
// Reset clears control and key registers; results cannot be stalled.
`include "hmac_sha256_setup_response_unit_assert.svh"
module hmac_sha256_setup_response_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  hsr_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output hsr_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [0:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StFold = 2'd2;

  logic [1:0]   state_q, state_d;
  logic [1:0]   blk_q, blk_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [127:0] key_q;
  hsr_pkg::req_t req_q;
  logic [255:0] h_q, h_d, st_q, st_d, st_nx, inner_q, inner_d;
  logic [511:0] w_q, w_d, w_nx, blk_data;
  logic         done_q, done_d;
  logic [511:0] kpad;

  hsr_round u_round (.st_i(st_q), .w_i(w_q), .rnd_i(rnd_q), .st_o(st_nx), .w_o(w_nx));

  assign busy_o = (state_q != StIdle);
  assign cfg_ready_o = !busy_o && !start_i;
  assign done_o = done_q;
  assign rsp_o = hsr_pkg::rsp_t'(h_q);

  always_comb begin
    kpad = {key_q, 384'b0};
    case (blk_d)
      2'd0: blk_data = kpad ^ {64{8'h36}};
      2'd1: blk_data = {32'h52454700, req_q, 8'h80, 232'b0, 64'd720};
      2'd2: blk_data = kpad ^ {64{8'h5c}};
      default: blk_data = {inner_q, 8'h80, 184'b0, 64'd768};
    endcase
  end

  always_comb begin
    state_d = state_q; blk_d = blk_q; rnd_d = rnd_q; h_d = h_q;
    st_d = st_q; w_d = w_q; inner_d = inner_q; done_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          blk_d = 2'd0; rnd_d = '0; h_d = hsr_pkg::HInit; st_d = hsr_pkg::HInit;
          state_d = StRound;
        end
      end
      StRound: begin
        st_d = st_nx; w_d = w_nx; rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = StFold;
      end
      StFold: begin
        for (int i = 0; i < 8; i++) begin
          h_d[255-32*i -: 32] = h_q[255-32*i -: 32] + st_q[255-32*i -: 32];
        end
        st_d = h_d;
        if (blk_q == 2'd1) begin
          inner_d = h_d; h_d = hsr_pkg::HInit; st_d = hsr_pkg::HInit;
        end
        blk_d = blk_q + 2'd1;
        if (blk_q == 2'd3) begin
          state_d = StIdle; done_d = 1'b1;
        end else begin
          state_d = StRound;
        end
      end
      default: state_d = StIdle;
    endcase
    if (state_d == StRound && rnd_d == 6'd0) w_d = blk_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; blk_q <= '0; rnd_q <= '0; done_q <= 1'b0; key_q <= '0;
    end else begin
      state_q <= state_d; blk_q <= blk_d; rnd_q <= rnd_d; done_q <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == hsr_pkg::CfgKeyUpper) key_q[127:64] <= cfg_data_i;
        else key_q[63:0] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d; st_q <= st_d; w_q <= w_d; inner_q <= inner_d;
    if (start_i && !busy_o) req_q <= req_i;
  end

  `HSR_ASSERT_NEXT(a_done_ends, done_o, !done_o)
  `HSR_ASSERT_IMPL(a_done_idle, done_o, state_q == StIdle)
  `HSR_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o && rnd_q == 6'd0)
  `HSR_ASSERT_IMPL(a_fold_wrap, state_q == StFold, rnd_q == 6'd0)
endmodule
